// ----- design/depth_to_color_registration_macros.svh -----
// Assertion shorthands shared by the registration design.
`ifndef DEPTH_TO_COLOR_REGISTRATION_MACROS_SVH
`define DEPTH_TO_COLOR_REGISTRATION_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define D2C_CHECK_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define D2C_CHECK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/d2c_pkg.sv -----
package d2c_pkg;

   // Register indexes of the configuration port.
   typedef enum logic [3:0] {
      CSR_DEPTH_FOCAL  = 4'd0,
      CSR_DEPTH_CENTER = 4'd1,
      CSR_COLOR_FOCAL  = 4'd2,
      CSR_COLOR_CENTER = 4'd3,
      CSR_ROT_ROW_ZERO = 4'd4,
      CSR_ROT_ROW_ONE  = 4'd5,
      CSR_ROT_ROW_TWO  = 4'd6,
      CSR_TRANSLATION  = 4'd7
   } d2c_csr_type;

   // Status of a divider result leaving the pipeline.
   typedef struct packed {
      logic valid;
      logic ovf;
   } d2c_div_stat_type;

   // Back-projection divider: |num| / |focal|, 40 quotient bits.
   localparam int BP_NUM_W = 58;
   localparam int BP_DEN_W = 32;
   localparam int BP_QUO_W = 40;

   // Projection divider: |num| / 2^16 / z, 17 quotient bits.
   localparam int PR_NUM_W = 47;
   localparam int PR_DEN_W = 30;
   localparam int PR_QUO_W = 17;

endpackage

// ----- design/d2c_div.sv -----
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// The overflow flag is set when the quotient does not fit in QUO_W bits.
module d2c_div import d2c_pkg::*; #(
   parameter int NUM_W  = 58,
   parameter int DEN_W  = 32,
   parameter int QUO_W  = 40,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output d2c_div_stat_type  out_stat,
   output logic [QUO_W-1:0]  out_quo,
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff [QUO_W+1];
   logic              ovf_ff   [QUO_W+1];
   logic [DEN_W-1:0]  rem_ff   [QUO_W+1];
   logic [DEN_W-1:0]  den_ff   [QUO_W+1];
   logic [QUO_W-1:0]  low_ff   [QUO_W+1];
   logic [QUO_W-1:0]  quo_ff   [QUO_W+1];
   logic [SIDE_W-1:0] side_ff  [QUO_W+1];

   logic              ovf_in;
   logic [DEN_W-1:0]  rem0_in;

   // The high numerator bits form the first partial remainder.
   always_comb begin
      ovf_in  = (in_num >> QUO_W) >= NUM_W'(in_den);
      rem0_in = DEN_W'(in_num >> QUO_W);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      ovf_ff[0]  <= ovf_in;
      rem_ff[0]  <= rem0_in;
      den_ff[0]  <= in_den;
      low_ff[0]  <= in_num[QUO_W-1:0];
      quo_ff[0]  <= '0;
      side_ff[0] <= in_side;
   end

   // Each stage brings down one numerator bit and tries a subtraction.
   for (genvar i = 1; i <= QUO_W; i++) begin : g_step
      logic [DEN_W+1:0] diff;
      logic             qbit_in;
      logic [DEN_W-1:0] rem_in;

      always_comb begin
         diff    = {1'b0, rem_ff[i-1], low_ff[i-1][QUO_W-1]} - {2'b00, den_ff[i-1]};
         qbit_in = !diff[DEN_W+1];
         rem_in  = qbit_in ? diff[DEN_W-1:0]
                           : {rem_ff[i-1][DEN_W-2:0], low_ff[i-1][QUO_W-1]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end

      always_ff @(posedge clock) begin
         ovf_ff[i]  <= ovf_ff[i-1];
         rem_ff[i]  <= rem_in;
         den_ff[i]  <= den_ff[i-1];
         low_ff[i]  <= {low_ff[i-1][QUO_W-2:0], 1'b0};
         quo_ff[i]  <= {quo_ff[i-1][QUO_W-2:0], qbit_in};
         side_ff[i] <= side_ff[i-1];
      end
   end

   assign out_stat.valid = valid_ff[QUO_W];
   assign out_stat.ovf   = ovf_ff[QUO_W];
   assign out_quo        = quo_ff[QUO_W];
   assign out_side       = side_ff[QUO_W];

endmodule

// ----- design/depth_to_color_registration.sv -----
// Maps one depth pixel per clock to a color image coordinate. A request is taken
// whenever start is high; busy stays low, so a new pixel may enter every cycle.
// The result appears on the rsp_ ports for one cycle with rsp_valid, in request
// order; the receiver cannot stall it, so it must take every result as it comes.
// The pipeline runs through the two pipelined dividers (41 stages for
// back-projection, 18 for projection) plus the multiply and add stages around
// them. Configuration registers may be written only while no request is in
// flight; csr_ready is always high.
`include "depth_to_color_registration_macros.svh"

module depth_to_color_registration import d2c_pkg::*; #(
   parameter int DEPTH_WIDTH  = 512,
   parameter int DEPTH_HEIGHT = 424,
   parameter int COLOR_WIDTH  = 1920,
   parameter int COLOR_HEIGHT = 1080
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [8:0]         req_pixel_column,
   input  logic [8:0]         req_pixel_row,
   input  logic [15:0]        req_depth_value,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_color_x,
   output logic signed [15:0] rsp_color_y,
   output logic               rsp_inside_color,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [63:0]        csr_wdata
);

   localparam int BP_SIDE_W = 18;
   localparam int PR_SIDE_W = 2;

   // ---------------------------------------------------------------- registers
   logic [63:0] depth_focal_ff, depth_center_ff, color_focal_ff, color_center_ff;
   logic [59:0] rot_row_ff [3];
   logic [62:0] translation_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         depth_focal_ff  <= '0;
         depth_center_ff <= '0;
         color_focal_ff  <= '0;
         color_center_ff <= '0;
         rot_row_ff[0]   <= '0;
         rot_row_ff[1]   <= '0;
         rot_row_ff[2]   <= '0;
         translation_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEPTH_FOCAL:  depth_focal_ff  <= csr_wdata;
            CSR_DEPTH_CENTER: depth_center_ff <= csr_wdata;
            CSR_COLOR_FOCAL:  color_focal_ff  <= csr_wdata;
            CSR_COLOR_CENTER: color_center_ff <= csr_wdata;
            CSR_ROT_ROW_ZERO: rot_row_ff[0]   <= csr_wdata[59:0];
            CSR_ROT_ROW_ONE:  rot_row_ff[1]   <= csr_wdata[59:0];
            CSR_ROT_ROW_TWO:  rot_row_ff[2]   <= csr_wdata[59:0];
            CSR_TRANSLATION:  translation_ff  <= csr_wdata[62:0];
            default: ;
         endcase
      end
   end

   logic signed [31:0] fxd, fyd, cxd, cyd, fxc, fyc, cxc, cyc;
   logic signed [19:0] coef [3][3];
   logic signed [20:0] trans [3];

   always_comb begin
      fxd = depth_focal_ff[63:32];
      fyd = depth_focal_ff[31:0];
      cxd = depth_center_ff[63:32];
      cyd = depth_center_ff[31:0];
      fxc = color_focal_ff[63:32];
      fyc = color_focal_ff[31:0];
      cxc = color_center_ff[63:32];
      cyc = color_center_ff[31:0];
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            coef[k][m] = rot_row_ff[k][20*m +: 20];
         end
         trans[k] = translation_ff[21*k +: 21];
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Pixel offset from the depth principal point and the reject checks.
   logic               s1_valid_ff, s1_kill_ff, s1_kill_in;
   logic signed [33:0] s1_ax_ff, s1_ay_ff, s1_ax_in, s1_ay_in;
   logic [15:0]        s1_depth_ff;

   always_comb begin
      s1_ax_in   = $signed({9'b0, req_pixel_column, 16'b0}) - 34'(cxd);
      s1_ay_in   = $signed({9'b0, req_pixel_row, 16'b0}) - 34'(cyd);
      s1_kill_in = (req_depth_value == 16'd0) || (fxd == 32'sd0) || (fyd == 32'sd0) ||
                   (32'(req_pixel_column) >= DEPTH_WIDTH) ||
                   (32'(req_pixel_row) >= DEPTH_HEIGHT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_ax_ff    <= s1_ax_in;
      s1_ay_ff    <= s1_ay_in;
      s1_kill_ff  <= s1_kill_in;
      s1_depth_ff <= req_depth_value;
   end

   // ---------------------------------------------------------------- stage 2
   // Offset times depth.
   logic               s2_valid_ff, s2_kill_ff;
   logic signed [50:0] s2_mx_ff, s2_my_ff, s2_mx_in, s2_my_in;
   logic [15:0]        s2_depth_ff;

   always_comb begin
      s2_mx_in = s1_ax_ff * $signed({1'b0, s1_depth_ff});
      s2_my_in = s1_ay_ff * $signed({1'b0, s1_depth_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_mx_ff    <= s2_mx_in;
      s2_my_ff    <= s2_my_in;
      s2_kill_ff  <= s1_kill_ff;
      s2_depth_ff <= s1_depth_ff;
   end

   // ---------------------------------------------------------------- stage 3
   // Magnitudes and quotient signs for the back-projection divide.
   logic                 s3_valid_ff;
   logic [BP_NUM_W-1:0]  s3_numx_ff, s3_numy_ff, s3_numx_in, s3_numy_in;
   logic [BP_DEN_W-1:0]  s3_denx_ff, s3_deny_ff, s3_denx_in, s3_deny_in;
   logic [BP_SIDE_W-1:0] s3_sidex_ff, s3_sidex_in;
   logic                 s3_negy_ff, s3_negy_in;
   logic [50:0]          s3_magx, s3_magy;

   always_comb begin
      s3_magx     = s2_mx_ff[50] ? 51'(-s2_mx_ff) : 51'(s2_mx_ff);
      s3_magy     = s2_my_ff[50] ? 51'(-s2_my_ff) : 51'(s2_my_ff);
      s3_numx_in  = {s3_magx[49:0], 8'b0};
      s3_numy_in  = {s3_magy[49:0], 8'b0};
      s3_denx_in  = fxd[31] ? 32'(-fxd) : 32'(fxd);
      s3_deny_in  = fyd[31] ? 32'(-fyd) : 32'(fyd);
      s3_sidex_in = {s2_kill_ff, s2_depth_ff, s2_mx_ff[50] ^ fxd[31]};
      s3_negy_in  = s2_my_ff[50] ^ fyd[31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_numx_ff  <= s3_numx_in;
      s3_numy_ff  <= s3_numy_in;
      s3_denx_ff  <= s3_denx_in;
      s3_deny_ff  <= s3_deny_in;
      s3_sidex_ff <= s3_sidex_in;
      s3_negy_ff  <= s3_negy_in;
   end

   // ---------------------------------------------------------------- divide X, Y
   d2c_div_stat_type     bpx_stat, bpy_stat;
   logic [BP_QUO_W-1:0]  bpx_quo, bpy_quo;
   logic [BP_SIDE_W-1:0] bpx_side;
   logic                 bpy_side;

   d2c_div #(
      .NUM_W (BP_NUM_W),
      .DEN_W (BP_DEN_W),
      .QUO_W (BP_QUO_W),
      .SIDE_W(BP_SIDE_W)
   ) u_div_bpx (
      .clock   (clock),
      .reset   (reset),
      .in_valid(s3_valid_ff),
      .in_num  (s3_numx_ff),
      .in_den  (s3_denx_ff),
      .in_side (s3_sidex_ff),
      .out_stat(bpx_stat),
      .out_quo (bpx_quo),
      .out_side(bpx_side)
   );

   d2c_div #(
      .NUM_W (BP_NUM_W),
      .DEN_W (BP_DEN_W),
      .QUO_W (BP_QUO_W),
      .SIDE_W(1)
   ) u_div_bpy (
      .clock   (clock),
      .reset   (reset),
      .in_valid(s3_valid_ff),
      .in_num  (s3_numy_ff),
      .in_den  (s3_deny_ff),
      .in_side (s3_negy_ff),
      .out_stat(bpy_stat),
      .out_quo (bpy_quo),
      .out_side(bpy_side)
   );

   // Apply the sign and clamp to signed 40 bits.
   function automatic logic signed [39:0] sat_bp(input logic [39:0] mag,
                                                 input logic ovf, input logic neg);
      logic signed [39:0] res;
      if (neg) begin
         if (ovf || mag > 40'h80_0000_0000) res = 40'sh80_0000_0000;
         else                               res = -$signed(mag);
      end else begin
         if (ovf || mag > 40'h7F_FFFF_FFFF) res = 40'sh7F_FFFF_FFFF;
         else                               res = $signed(mag);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- stage 4
   // Depth-camera point in Q.8 mm.
   logic               s4_valid_ff, s4_kill_ff;
   logic signed [39:0] s4_p_ff [3];
   logic signed [39:0] s4_p_in [3];

   always_comb begin
      s4_p_in[0] = sat_bp(bpx_quo, bpx_stat.ovf, bpx_side[0]);
      s4_p_in[1] = sat_bp(bpy_quo, bpy_stat.ovf, bpy_side);
      s4_p_in[2] = $signed({16'b0, bpx_side[16:1], 8'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= bpx_stat.valid;
      end
   end

   always_ff @(posedge clock) begin
      s4_p_ff    <= s4_p_in;
      s4_kill_ff <= bpx_side[17];
   end

   // ---------------------------------------------------------------- stage 5
   // Nine rotation products.
   logic               s5_valid_ff, s5_kill_ff;
   logic signed [59:0] s5_prod_ff [3][3];
   logic signed [59:0] s5_prod_in [3][3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            s5_prod_in[k][m] = coef[k][m] * s4_p_ff[m];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_prod_ff <= s5_prod_in;
      s5_kill_ff <= s4_kill_ff;
   end

   // ---------------------------------------------------------------- stage 6
   // Row sums plus translation, Q.26.
   logic               s6_valid_ff, s6_kill_ff;
   logic signed [62:0] s6_sum_ff [3];
   logic signed [62:0] s6_sum_in [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s6_sum_in[k] = 63'(s5_prod_ff[k][0]) + 63'(s5_prod_ff[k][1]) +
                        63'(s5_prod_ff[k][2]) + 63'($signed({trans[k], 21'b0}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s6_sum_ff  <= s6_sum_in;
      s6_kill_ff <= s5_kill_ff;
   end

   // ---------------------------------------------------------------- stage 7
   // Back to Q.8 with truncation toward zero, clamp to signed 31 bits.
   localparam logic signed [62:0] Q_HI = 63'sd1073741823;
   localparam logic signed [62:0] Q_LO = -63'sd1073741824;

   logic               s7_valid_ff, s7_kill_ff;
   logic signed [30:0] s7_q_ff [3];
   logic signed [30:0] s7_q_in [3];
   logic signed [62:0] s7_shift [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s7_shift[k] = (s6_sum_ff[k] + (s6_sum_ff[k][62] ? 63'sd262143 : 63'sd0)) >>> 18;
         if (s7_shift[k] > Q_HI)      s7_q_in[k] = 31'(Q_HI);
         else if (s7_shift[k] < Q_LO) s7_q_in[k] = 31'(Q_LO);
         else                         s7_q_in[k] = 31'(s7_shift[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_q_ff    <= s7_q_in;
      s7_kill_ff <= s6_kill_ff;
   end

   // ---------------------------------------------------------------- stage 8
   // Projection products; a point at or behind the color camera is rejected.
   logic               s8_valid_ff, s8_kill_ff, s8_kill_in;
   logic signed [62:0] s8_fx_ff, s8_fy_ff, s8_cx_ff, s8_cy_ff;
   logic signed [62:0] s8_fx_in, s8_fy_in, s8_cx_in, s8_cy_in;
   logic [29:0]        s8_z_ff;

   always_comb begin
      s8_fx_in   = s7_q_ff[0] * fxc;
      s8_fy_in   = s7_q_ff[1] * fyc;
      s8_cx_in   = cxc * s7_q_ff[2];
      s8_cy_in   = cyc * s7_q_ff[2];
      s8_kill_in = s7_kill_ff || (s7_q_ff[2] <= 31'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s8_fx_ff   <= s8_fx_in;
      s8_fy_ff   <= s8_fy_in;
      s8_cx_ff   <= s8_cx_in;
      s8_cy_ff   <= s8_cy_in;
      s8_z_ff    <= s7_q_ff[2][29:0];
      s8_kill_ff <= s8_kill_in;
   end

   // ---------------------------------------------------------------- stage 9
   // Drop the fraction of the focal product toward zero.
   logic               s9_valid_ff, s9_kill_ff;
   logic signed [63:0] s9_tx_ff, s9_ty_ff, s9_tx_in, s9_ty_in;
   logic signed [62:0] s9_cx_ff, s9_cy_ff;
   logic [29:0]        s9_z_ff;
   logic [62:0]        s9_magx, s9_magy;

   always_comb begin
      s9_magx  = s8_fx_ff[62] ? 63'(-s8_fx_ff) : 63'(s8_fx_ff);
      s9_magy  = s8_fy_ff[62] ? 63'(-s8_fy_ff) : 63'(s8_fy_ff);
      s9_tx_in = $signed({1'b0, s9_magx[62:24], 24'b0});
      s9_ty_in = $signed({1'b0, s9_magy[62:24], 24'b0});
      if (s8_fx_ff[62]) s9_tx_in = -s9_tx_in;
      if (s8_fy_ff[62]) s9_ty_in = -s9_ty_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s9_tx_ff   <= s9_tx_in;
      s9_ty_ff   <= s9_ty_in;
      s9_cx_ff   <= s8_cx_ff;
      s9_cy_ff   <= s8_cy_ff;
      s9_z_ff    <= s8_z_ff;
      s9_kill_ff <= s8_kill_ff;
   end

   // ---------------------------------------------------------------- stage 10
   // Add the principal point term.
   logic               s10_valid_ff, s10_kill_ff;
   logic signed [63:0] s10_nx_ff, s10_ny_ff, s10_nx_in, s10_ny_in;
   logic [29:0]        s10_z_ff;

   always_comb begin
      s10_nx_in = s9_tx_ff + 64'(s9_cx_ff);
      s10_ny_in = s9_ty_ff + 64'(s9_cy_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else begin
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s10_nx_ff   <= s10_nx_in;
      s10_ny_ff   <= s10_ny_in;
      s10_z_ff    <= s9_z_ff;
      s10_kill_ff <= s9_kill_ff;
   end

   // ---------------------------------------------------------------- stage 11
   // Magnitude over 2^16; the divide by z finishes the truncation.
   logic                 s11_valid_ff;
   logic [PR_NUM_W-1:0]  s11_numx_ff, s11_numy_ff;
   logic [PR_DEN_W-1:0]  s11_z_ff;
   logic [PR_SIDE_W-1:0] s11_sidex_ff;
   logic                 s11_negy_ff;
   logic [63:0]          s11_magx, s11_magy;

   always_comb begin
      s11_magx = s10_nx_ff[63] ? 64'(-s10_nx_ff) : 64'(s10_nx_ff);
      s11_magy = s10_ny_ff[63] ? 64'(-s10_ny_ff) : 64'(s10_ny_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else begin
         s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s11_numx_ff  <= s11_magx[62:16];
      s11_numy_ff  <= s11_magy[62:16];
      s11_z_ff     <= s10_z_ff;
      s11_sidex_ff <= {s10_kill_ff, s10_nx_ff[63]};
      s11_negy_ff  <= s10_ny_ff[63];
   end

   // ---------------------------------------------------------------- divide by z
   d2c_div_stat_type     prx_stat, pry_stat;
   logic [PR_QUO_W-1:0]  prx_quo, pry_quo;
   logic [PR_SIDE_W-1:0] prx_side;
   logic                 pry_side;

   d2c_div #(
      .NUM_W (PR_NUM_W),
      .DEN_W (PR_DEN_W),
      .QUO_W (PR_QUO_W),
      .SIDE_W(PR_SIDE_W)
   ) u_div_prx (
      .clock   (clock),
      .reset   (reset),
      .in_valid(s11_valid_ff),
      .in_num  (s11_numx_ff),
      .in_den  (s11_z_ff),
      .in_side (s11_sidex_ff),
      .out_stat(prx_stat),
      .out_quo (prx_quo),
      .out_side(prx_side)
   );

   d2c_div #(
      .NUM_W (PR_NUM_W),
      .DEN_W (PR_DEN_W),
      .QUO_W (PR_QUO_W),
      .SIDE_W(1)
   ) u_div_pry (
      .clock   (clock),
      .reset   (reset),
      .in_valid(s11_valid_ff),
      .in_num  (s11_numy_ff),
      .in_den  (s11_z_ff),
      .in_side (s11_negy_ff),
      .out_stat(pry_stat),
      .out_quo (pry_quo),
      .out_side(pry_side)
   );

   // Apply the sign and clamp to signed 16 bits.
   function automatic logic signed [15:0] sat_px(input logic [16:0] mag,
                                                 input logic ovf, input logic neg);
      logic signed [15:0] res;
      if (neg) begin
         if (ovf || mag > 17'd32768) res = -16'sd32768;
         else                        res = 16'(-$signed({1'b0, mag}));
      end else begin
         if (ovf || mag > 17'd32767) res = 16'sd32767;
         else                        res = 16'(mag);
      end
      return res;
   endfunction

   // ---------------------------------------------------------------- output
   // Inside test on the unclamped quotient: overflow means far outside.
   logic               out_kill, x_pos, x_low, y_pos, y_low;
   logic               rsp_valid_ff, rsp_inside_ff, rsp_inside_in;
   logic signed [15:0] rsp_x_ff, rsp_y_ff, rsp_x_in, rsp_y_in;

   always_comb begin
      out_kill = prx_side[1];
      x_pos    = !prx_side[0] && (prx_stat.ovf || prx_quo != '0);
      x_low    = prx_side[0] || (!prx_stat.ovf && 32'(prx_quo) < COLOR_WIDTH);
      y_pos    = !pry_side && (pry_stat.ovf || pry_quo != '0);
      y_low    = pry_side || (!pry_stat.ovf && 32'(pry_quo) < COLOR_HEIGHT);
      if (out_kill) begin
         rsp_x_in      = '0;
         rsp_y_in      = '0;
         rsp_inside_in = 1'b0;
      end else begin
         rsp_x_in      = sat_px(prx_quo, prx_stat.ovf, prx_side[0]);
         rsp_y_in      = sat_px(pry_quo, pry_stat.ovf, pry_side);
         rsp_inside_in = x_pos && x_low && y_pos && y_low;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= prx_stat.valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_color_x      = rsp_x_ff;
   assign rsp_color_y      = rsp_y_ff;
   assign rsp_inside_color = rsp_inside_ff;

   // ---------------------------------------------------------------- checks
   `D2C_CHECK_NOW(a_inside_x, clock, reset, rsp_valid && rsp_inside_color, (rsp_color_x > 16'sd0) && (rsp_color_x < COLOR_WIDTH), "inside flag with column outside the color image")
   `D2C_CHECK_NOW(a_inside_y, clock, reset, rsp_valid && rsp_inside_color, (rsp_color_y > 16'sd0) && (rsp_color_y < COLOR_HEIGHT), "inside flag with row outside the color image")
   `D2C_CHECK_NEXT(a_kill_zero, clock, reset, prx_stat.valid && out_kill, rsp_valid && (rsp_color_x == 16'sd0) && (rsp_color_y == 16'sd0) && !rsp_inside_color, "rejected request did not give a zero result")
   `D2C_CHECK_NOW(a_div_lockstep, clock, reset, 1'b1, (bpx_stat.valid == bpy_stat.valid) && (prx_stat.valid == pry_stat.valid), "paired dividers out of step")

endmodule
